// ===== design/shift_or_substring_matcher_top_assert.svh =====
// ----------------------------------------------------------------------------
// Shift-Or matcher assertion macros
// Concurrent assertion helpers used by the matcher table engine; clk and rst_n are
// taken from the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SHIFT_OR_SUBSTRING_MATCHER_TOP_ASSERT_SVH
`define SHIFT_OR_SUBSTRING_MATCHER_TOP_ASSERT_SVH

// same-cycle implication
`define SSM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// Shift-Or matcher package
// Beat types, operation codes and fixed field widths of the matcher.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int CODE_W     = 16;
    localparam int POS_W      = 5;
    localparam int LEN_W      = 6;
    localparam int START_W    = 16;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    localparam logic [1:0] OP_TEXT    = 2'd0;
    localparam logic [1:0] OP_MARK    = 2'd1;
    localparam logic [1:0] OP_RESTORE = 2'd2;

    typedef enum logic [1:0] {
        CMD_TEXT    = 2'd0,
        CMD_MARK    = 2'd1,
        CMD_RESTORE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [CODE_W-1:0] char_code;
        logic [CODE_W-1:0] other_case_code;
        logic              fold_case;
        logic [POS_W-1:0]  pattern_position;
        logic              last_in_line;
    } item_t;

    typedef struct packed {
        logic               matched;
        logic [START_W-1:0] match_start;
    } result_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  pos;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== design/ssm_front.sv =====
// ----------------------------------------------------------------------------
// Shift-Or matcher front end
// Accepts input beats, classifies them into commands and splits case-folded
// table updates into two commands for the command queue.
// ----------------------------------------------------------------------------
module ssm_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ssm_pkg::item_t     item,
    output logic               full,
    input  logic               clearing,
    input  ssm_pkg::q_status_t cmdq_stat,
    output logic               cmd_push,
    output ssm_pkg::cmd_t      cmd
);

    logic          hold_valid_reg;
    logic          hold_valid_next;
    ssm_pkg::cmd_t hold_cmd_reg;
    ssm_pkg::cmd_t hold_cmd_next;
    ssm_pkg::cmd_t primary;
    logic          accept;
    logic          op_known;
    logic          is_table_op;

    assign full   = hold_valid_reg || cmdq_stat.full || clearing;
    assign accept = push && !full;

    always_comb
    begin
        primary.code = item.char_code;
        primary.pos  = item.pattern_position;
        primary.last = item.last_in_line;
        op_known     = 1'b1;
        is_table_op  = 1'b0;
        unique case (item.op)
            ssm_pkg::OP_TEXT:
            begin
                primary.kind = ssm_pkg::CMD_TEXT;
            end
            ssm_pkg::OP_MARK:
            begin
                primary.kind = ssm_pkg::CMD_MARK;
                is_table_op  = 1'b1;
            end
            ssm_pkg::OP_RESTORE:
            begin
                primary.kind = ssm_pkg::CMD_RESTORE;
                is_table_op  = 1'b1;
            end
            default:
            begin
                primary.kind = ssm_pkg::CMD_TEXT;
                op_known     = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        cmd             = primary;
        cmd_push        = 1'b0;
        if (hold_valid_reg)
        begin
            cmd      = hold_cmd_reg;
            cmd_push = !cmdq_stat.full;
            if (!cmdq_stat.full)
            begin
                hold_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            cmd_push = op_known;
            if (item.fold_case && is_table_op)
            begin
                hold_valid_next    = 1'b1;
                hold_cmd_next      = primary;
                hold_cmd_next.code = item.other_case_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

// ===== design/ssm_cmdq.sv =====
// ----------------------------------------------------------------------------
// Shift-Or matcher command queue
// Short FIFO between the front end and the table engine.
// ----------------------------------------------------------------------------
module ssm_cmdq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_en,
    input  ssm_pkg::cmd_t      push_cmd,
    input  logic               pop_en,
    output ssm_pkg::cmd_t      head,
    output ssm_pkg::q_status_t stat
);

    localparam int AW = ssm_pkg::CMDQ_AW;

    ssm_pkg::cmd_t q_mem [ssm_pkg::CMDQ_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW:0]   count_reg;
    logic [AW:0]   count_next;
    logic          do_push;
    logic          do_pop;

    assign stat.full  = (count_reg == (AW+1)'(ssm_pkg::CMDQ_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push_en && !stat.full;
    assign do_pop     = pop_en && !stat.empty;
    assign head       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/ssm_back.sv =====
// ----------------------------------------------------------------------------
// Shift-Or matcher table engine
// Holds the character mask table, runs the post-reset clearing sweep,
// updates the match register per text character and queues result beats.
// ----------------------------------------------------------------------------
`include "shift_or_substring_matcher_top_assert.svh"

module ssm_back
#(
    parameter int MASK_BITS   = 32,
    parameter int CHAR_BITS   = 16,
    parameter int OFFSET_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wen,
    input  logic [ssm_pkg::LEN_W-1:0]  cfg_wdata,
    input  ssm_pkg::cmd_t              head,
    input  ssm_pkg::q_status_t         q_stat,
    output logic                       cmd_pop,
    output logic                       clearing,
    output ssm_pkg::result_t           result,
    output logic                       empty,
    input  logic                       pop
);

    localparam int TABLE_DEPTH = 1 << CHAR_BITS;
    localparam int IDX_W       = $clog2(MASK_BITS);
    localparam int LW          = ssm_pkg::LEN_W + 1;
    localparam int SW          = (OFFSET_BITS + 1 > ssm_pkg::START_W) ?
                                 OFFSET_BITS + 1 : ssm_pkg::START_W;
    localparam logic [MASK_BITS-1:0]   ALL_ONES = {MASK_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
    localparam logic [CHAR_BITS-1:0]   ADDR_MAX = {CHAR_BITS{1'b1}};

    logic [MASK_BITS-1:0] mem [TABLE_DEPTH];

    logic                      clearing_reg;
    logic                      clearing_next;
    logic [CHAR_BITS-1:0]      clear_addr_reg;
    logic [CHAR_BITS-1:0]      clear_addr_next;
    logic [ssm_pkg::LEN_W-1:0] len_cfg_reg;
    logic                      s2_valid_reg;
    ssm_pkg::cmd_t             s2_cmd_reg;
    logic [MASK_BITS-1:0]      rd_data_reg;
    logic                      fwd_valid_reg;
    logic [CHAR_BITS-1:0]      fwd_addr_reg;
    logic [MASK_BITS-1:0]      fwd_data_reg;
    logic [MASK_BITS-1:0]      shift_reg;
    logic [MASK_BITS-1:0]      shift_next;
    logic [OFFSET_BITS-1:0]    offset_reg;
    logic [OFFSET_BITS-1:0]    offset_next;
    logic                      found_reg;
    logic                      found_next;

    ssm_pkg::result_t rq_mem [2];
    logic             rq_wr_reg;
    logic             rq_rd_reg;
    logic [1:0]       rq_count_reg;
    logic [1:0]       rq_count_next;
    logic             rq_full;
    logic             rq_pop;

    logic                 advance;
    logic                 exec;
    logic [CHAR_BITS-1:0] s2_addr;
    logic [MASK_BITS-1:0] entry;
    logic [MASK_BITS-1:0] bit_sel;
    logic                 op_wr;
    logic [MASK_BITS-1:0] op_wr_data;
    logic                 tw_en;
    logic [CHAR_BITS-1:0] tw_addr;
    logic [MASK_BITS-1:0] tw_data;
    logic [LW-1:0]        len_raw;
    logic [LW-1:0]        len_eff;
    logic [LW-1:0]        len_m1;
    logic [MASK_BITS-1:0] shift_cand;
    logic                 hit;
    logic [SW-1:0]        sum;
    logic [SW-1:0]        len_s;
    logic [SW-1:0]        start;
    logic                 res_push;
    ssm_pkg::result_t     res_val;

    assign clearing = clearing_reg;
    assign rq_full  = (rq_count_reg == 2'd2);
    assign advance  = !rq_full;
    assign cmd_pop  = advance && !q_stat.empty && !clearing_reg;
    assign exec     = s2_valid_reg && advance;
    assign s2_addr  = s2_cmd_reg.code[CHAR_BITS-1:0];
    assign entry    = (fwd_valid_reg && (fwd_addr_reg == s2_addr)) ?
                      fwd_data_reg : rd_data_reg;
    assign bit_sel  = {{(MASK_BITS-1){1'b0}}, 1'b1} << s2_cmd_reg.pos;
    assign empty    = (rq_count_reg == 2'd0);
    assign rq_pop   = pop && !empty;
    assign result   = rq_mem[rq_rd_reg];

    always_comb
    begin
        op_wr      = 1'b0;
        op_wr_data = ALL_ONES;
        if (exec)
        begin
            unique case (s2_cmd_reg.kind)
                ssm_pkg::CMD_MARK:
                begin
                    op_wr      = 1'b1;
                    op_wr_data = entry & ~bit_sel;
                end
                ssm_pkg::CMD_RESTORE:
                begin
                    op_wr = 1'b1;
                end
                default:
                begin
                    op_wr = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            tw_en   = 1'b1;
            tw_addr = clear_addr_reg;
            tw_data = ALL_ONES;
        end
        else
        begin
            tw_en   = op_wr;
            tw_addr = s2_addr;
            tw_data = op_wr_data;
        end
        clearing_next   = clearing_reg && (clear_addr_reg != ADDR_MAX);
        clear_addr_next = clearing_reg ? clear_addr_reg + CHAR_BITS'(1) : clear_addr_reg;
    end

    always_comb
    begin
        len_raw = {1'b0, len_cfg_reg};
        priority if (len_raw == '0)
        begin
            len_eff = LW'(1);
        end
        else if (len_raw > LW'(MASK_BITS))
        begin
            len_eff = LW'(MASK_BITS);
        end
        else
        begin
            len_eff = len_raw;
        end
        len_m1     = len_eff - LW'(1);
        shift_cand = {shift_reg[MASK_BITS-2:0], 1'b0} | entry;
        hit        = !shift_cand[len_m1[IDX_W-1:0]];
        sum        = SW'(offset_reg) + SW'(1);
        len_s      = SW'(len_eff);
        start      = (sum >= len_s) ? sum - len_s : '0;
    end

    always_comb
    begin
        shift_next            = shift_reg;
        offset_next           = offset_reg;
        found_next            = found_reg;
        res_push              = 1'b0;
        res_val.matched       = 1'b0;
        res_val.match_start   = '0;
        if (exec && (s2_cmd_reg.kind == ssm_pkg::CMD_TEXT))
        begin
            if (!found_reg)
            begin
                shift_next = shift_cand;
                if (hit)
                begin
                    found_next          = 1'b1;
                    res_push            = 1'b1;
                    res_val.matched     = 1'b1;
                    res_val.match_start = start[ssm_pkg::START_W-1:0];
                end
                else if (s2_cmd_reg.last)
                begin
                    res_push = 1'b1;
                end
            end
            if (offset_reg != OFF_MAX)
            begin
                offset_next = offset_reg + OFFSET_BITS'(1);
            end
            if (s2_cmd_reg.last)
            begin
                shift_next  = ALL_ONES;
                offset_next = '0;
                found_next  = 1'b0;
            end
        end
        rq_count_next = rq_count_reg + 2'(res_push) - 2'(rq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            len_cfg_reg    <= ssm_pkg::LEN_W'(1);
            s2_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            shift_reg      <= ALL_ONES;
            offset_reg     <= '0;
            found_reg      <= 1'b0;
            rq_wr_reg      <= 1'b0;
            rq_rd_reg      <= 1'b0;
            rq_count_reg   <= 2'd0;
        end
        else
        begin
            clearing_reg   <= clearing_next;
            clear_addr_reg <= clear_addr_next;
            if (cfg_wen)
            begin
                len_cfg_reg <= cfg_wdata;
            end
            if (advance)
            begin
                s2_valid_reg  <= cmd_pop;
                fwd_valid_reg <= op_wr;
            end
            shift_reg    <= shift_next;
            offset_reg   <= offset_next;
            found_reg    <= found_next;
            rq_wr_reg    <= rq_wr_reg ^ res_push;
            rq_rd_reg    <= rq_rd_reg ^ rq_pop;
            rq_count_reg <= rq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tw_en)
        begin
            mem[tw_addr] <= tw_data;
        end
        if (cmd_pop)
        begin
            rd_data_reg <= mem[head.code[CHAR_BITS-1:0]];
            s2_cmd_reg  <= head;
        end
        if (advance)
        begin
            fwd_addr_reg <= s2_addr;
            fwd_data_reg <= op_wr_data;
        end
        if (res_push)
        begin
            rq_mem[rq_wr_reg] <= res_val;
        end
    end

    `SSM_ASSERT_IMPLY(a_clear_quiet, clearing_reg, !s2_valid_reg && !cmd_pop, "op during clearing sweep")
    `SSM_ASSERT_IMPLY(a_rq_room, res_push, rq_count_reg != 2'd2, "result beat into full queue")
    `SSM_ASSERT_NEXT(a_pop_lands, cmd_pop, s2_valid_reg, "popped command lost")
    `SSM_ASSERT_IMPLY(a_res_text, res_push, s2_valid_reg && (s2_cmd_reg.kind == ssm_pkg::CMD_TEXT), "result from non-text op")

endmodule

// ===== design/shift_or_substring_matcher_top.sv =====
// ----------------------------------------------------------------------------
// Shift-Or substring matcher
// Bitap search over lines of 16-bit characters with a per-character mask
// table, fed by a classifying front end through a short command queue.
// ----------------------------------------------------------------------------
// After reset the block sweeps the mask table to all ones, one entry a cycle,
// so full stays high until every entry has been written, before the first
// beat is taken. Then a text or plain mark/restore beat is taken every cycle
// while the command queue has room; a case-folded mark or restore is split
// into two commands, one table write per entry through the single table write
// port, and full stays high while the second one is held. A result beat
// passes in order through the command queue, the registered table read and
// the match-state update that queues the result; a full result queue stalls
// the engine. Up to two results wait in the output queue while pop is low.
// ----------------------------------------------------------------------------
module shift_or_substring_matcher_top
#(
    parameter int MASK_BITS   = 32,
    parameter int CHAR_BITS   = 16,
    parameter int OFFSET_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wen,
    input  logic [ssm_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                      push,
    input  ssm_pkg::item_t            item,
    output logic                      full,
    output logic                      empty,
    input  logic                      pop,
    output ssm_pkg::result_t          result
);

    ssm_pkg::q_status_t cmdq_stat;
    ssm_pkg::cmd_t      front_cmd;
    ssm_pkg::cmd_t      cmdq_head;
    logic               front_push;
    logic               back_pop;
    logic               clearing;

    ssm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .clearing  (clearing),
        .cmdq_stat (cmdq_stat),
        .cmd_push  (front_push),
        .cmd       (front_cmd)
    );

    ssm_cmdq u_cmdq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_en  (front_push),
        .push_cmd (front_cmd),
        .pop_en   (back_pop),
        .head     (cmdq_head),
        .stat     (cmdq_stat)
    );

    ssm_back
    #(
        .MASK_BITS   (MASK_BITS),
        .CHAR_BITS   (CHAR_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .head      (cmdq_head),
        .q_stat    (cmdq_stat),
        .cmd_pop   (back_pop),
        .clearing  (clearing),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
